// ===== sv/circle_point_generator_unit_defines.svh =====
// Assertion macros for the circle point generator.
`ifndef CIRCLE_POINT_GENERATOR_UNIT_DEFINES_SVH
`define CIRCLE_POINT_GENERATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define CPG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpg assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define CPG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpg assertion failed");
`else
`define CPG_ASSERT_IMP(lbl, ante, cons)
`define CPG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/cpg_pkg.sv =====
`default_nettype none
package cpg_pkg;

	localparam int X_W     = 9;
	localparam int Y_W     = 9;
	localparam int YS_W    = 8;
	localparam int ENTRY_W = X_W + YS_W;
	localparam int CNT_W   = 10;
	localparam int K_W     = CNT_W + 2;
	localparam int D_W     = 14;
	localparam int P_W     = 17;
	localparam int R_W     = 8;
	localparam int C_W     = 12;
	localparam int PT_W    = 13;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_RADIUS   = 2'd2;

	typedef struct packed {
		logic [X_W-1:0]        x;
		logic [Y_W-1:0]        y;
		logic signed [D_W-1:0] d;
	} walk_t;

	typedef struct packed {
		logic [CNT_W-1:0] idx;
		logic             neg_x;
		logic             neg_y;
		logic             last;
	} replay_sel_t;

endpackage
`default_nettype wire

// ===== sv/circle_point_generator_unit.sv =====
// Circle outline generator. A restart item takes the radius, walks one
// quadrant with the midpoint test and stores it, one step per cycle; input is
// held for its n steps (n <= 2r) and the issue of the first point, longer
// while the output is stalled, bound by the single write port of the quadrant
// store. Each advance item then yields the next point of the closed 4n-point
// outline at one item per cycle unless the output stalls; an item's entry is
// registered in a first stage, then in the result register once the output is
// free. Advances while idle or past the last point yield nothing. The store is
// not cleared after reset: entries are always written before being read.
`default_nettype none
`include "circle_point_generator_unit_defines.svh"
module circle_point_generator_unit #(
	parameter int MAX_RADIUS  = 255,
	parameter int STORE_DEPTH = 512
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [cpg_pkg::IDX_W-1:0]        cfg_index,
	input  wire logic [cpg_pkg::C_W-1:0]          cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             restart,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [cpg_pkg::PT_W-1:0]       point_x,
	output logic signed [cpg_pkg::PT_W-1:0]       point_y,
	output logic                                  last_point
);

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int RLIM = (MAX_RADIUS < (STORE_DEPTH - 1) / 2) ?
		MAX_RADIUS : (STORE_DEPTH - 1) / 2;
	localparam int CNT_W = cpg_pkg::CNT_W;
	localparam int PT_W  = cpg_pkg::PT_W;
	localparam int D_W   = cpg_pkg::D_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUILD,
		ST_FIRST,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [cpg_pkg::C_W-1:0]         center_x_q;
	logic [cpg_pkg::C_W-1:0]         center_y_q;
	logic [cpg_pkg::R_W-1:0]         radius_q;
	logic [cpg_pkg::X_W-1:0]         step_x_q;
	logic [cpg_pkg::Y_W-1:0]         step_y_q;
	logic signed [D_W-1:0]           d_q;
	logic [CNT_W-1:0]                quad_cnt_q;
	logic [cpg_pkg::K_W-1:0]         replay_idx_q;
	logic [cpg_pkg::ENTRY_W-1:0]     store_q [STORE_DEPTH];

	logic [cpg_pkg::ENTRY_W-1:0]     entry_s1;
	logic                            valid_s1;
	logic                            neg_x_s1;
	logic                            neg_y_s1;
	logic                            last_s1;

	logic [cpg_pkg::R_W-1:0]         r_eff;
	cpg_pkg::walk_t                  walk_nxt;
	cpg_pkg::replay_sel_t            sel;
	logic                            in_accept;
	logic                            out_free;
	logic                            s1_move;
	logic                            s1_can_load;
	logic                            emit_go;
	logic                            wr_en;
	logic [AW-1:0]                   wr_addr;
	logic [cpg_pkg::ENTRY_W-1:0]     wr_data;
	logic signed [PT_W-1:0]          off_x;
	logic signed [PT_W-1:0]          off_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cpg_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				cpg_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				cpg_pkg::REG_RADIUS:   radius_q   <= cfg_data[cpg_pkg::R_W-1:0];
				default: ;
			endcase
		end
	end

	assign r_eff = (32'(radius_q) > RLIM) ? cpg_pkg::R_W'(RLIM) : radius_q;

	cpg_walker u_walker (
		.x   (step_x_q),
		.y   (step_y_q),
		.d   (d_q),
		.nxt (walk_nxt)
	);

	cpg_replay u_replay (
		.k   (replay_idx_q),
		.n   (quad_cnt_q),
		.sel (sel)
	);

	assign out_free    = !out_valid || !out_stall;
	assign s1_move     = valid_s1 && out_free;
	assign s1_can_load = !valid_s1 || out_free;
	assign in_stall    = (state_q == ST_BUILD) || (state_q == ST_FIRST) || !s1_can_load;
	assign in_accept   = in_valid && !in_stall;
	assign emit_go     = ((state_q == ST_FIRST) && s1_can_load) ||
		(in_accept && !restart && (state_q == ST_EMIT));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = {{cpg_pkg::X_W{1'b0}}, r_eff};
		if (in_accept && restart && (r_eff != '0)) begin
			wr_en = 1'b1;
		end else if (state_q == ST_BUILD) begin
			wr_en   = 1'b1;
			wr_addr = AW'(quad_cnt_q + CNT_W'(1));
			wr_data = {walk_nxt.x, walk_nxt.y[cpg_pkg::YS_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_x_q     <= '0;
			step_y_q     <= '0;
			d_q          <= '0;
			quad_cnt_q   <= '0;
			replay_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE, ST_EMIT: begin
					if (in_accept && restart) begin
						replay_idx_q <= '0;
						quad_cnt_q   <= '0;
						if (r_eff == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q  <= ST_BUILD;
							step_x_q <= '0;
							step_y_q <= cpg_pkg::Y_W'(r_eff);
							d_q      <= signed'(D_W'(2)) - signed'(D_W'({r_eff, 1'b0}));
						end
					end else if (emit_go) begin
						if (sel.last) begin
							state_q      <= ST_IDLE;
							replay_idx_q <= '0;
						end else begin
							replay_idx_q <= replay_idx_q + cpg_pkg::K_W'(1);
						end
					end
				end
				ST_BUILD: begin
					step_x_q   <= walk_nxt.x;
					step_y_q   <= walk_nxt.y;
					d_q        <= walk_nxt.d;
					quad_cnt_q <= quad_cnt_q + CNT_W'(1);
					if (walk_nxt.y == '0) begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					if (emit_go) begin
						if (sel.last) begin
							state_q      <= ST_IDLE;
							replay_idx_q <= '0;
						end else begin
							state_q      <= ST_EMIT;
							replay_idx_q <= replay_idx_q + cpg_pkg::K_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			entry_s1 <= store_q[AW'(sel.idx)];
			neg_x_s1 <= sel.neg_x;
			neg_y_s1 <= sel.neg_y;
			last_s1  <= sel.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (emit_go) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		off_x = signed'(PT_W'(entry_s1[cpg_pkg::ENTRY_W-1:cpg_pkg::YS_W]));
		off_y = signed'(PT_W'(entry_s1[cpg_pkg::YS_W-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_move) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			point_x    <= PT_W'(signed'(center_x_q)) + (neg_x_s1 ? -off_x : off_x);
			point_y    <= PT_W'(signed'(center_y_q)) + (neg_y_s1 ? off_y : -off_y);
			last_point <= last_s1;
		end
	end

	`CPG_ASSERT_IMP(a_build_holds_input, state_q == ST_BUILD, in_stall)
	`CPG_ASSERT_IMP(a_full_s1_holds_input, valid_s1 && out_valid && out_stall, in_stall)
	`CPG_ASSERT_NXT(a_first_then_emit, (state_q == ST_FIRST) && emit_go, state_q == ST_EMIT)
	`CPG_ASSERT_IMP(a_replay_in_range, state_q == ST_EMIT,
		replay_idx_q < (cpg_pkg::K_W'(quad_cnt_q) << 2))

endmodule
`default_nettype wire

// ===== sv/cpg_walker.sv =====
`default_nettype none
module cpg_walker (
	input  wire logic [cpg_pkg::X_W-1:0]        x,
	input  wire logic [cpg_pkg::Y_W-1:0]        y,
	input  wire logic signed [cpg_pkg::D_W-1:0] d,
	output cpg_pkg::walk_t                      nxt
);

	localparam int P_W = cpg_pkg::P_W;
	localparam int D_W = cpg_pkg::D_W;

	logic signed [P_W-1:0] d4;
	logic signed [P_W-1:0] xe;
	logic signed [P_W-1:0] ye;
	logic signed [P_W-1:0] p_in;
	logic signed [P_W-1:0] p_out;
	logic signed [D_W-1:0] inc_x;
	logic signed [D_W-1:0] inc_y;
	logic                  dx;
	logic                  dy;

	// d tracks (x+1)^2 + (y-1)^2 - r^2; the scaled half-pixel tests derive from it
	always_comb begin
		d4    = P_W'(d) <<< 2;
		xe    = signed'(P_W'(x));
		ye    = signed'(P_W'(y));
		p_in  = d4 + (ye <<< 2) - signed'(P_W'(3));
		p_out = d4 - (xe <<< 2) - signed'(P_W'(3));
		dx    = 1'b1;
		dy    = 1'b1;
		if (d < 0) begin
			dy = (p_in > 0);
		end else if (d > 0) begin
			dx = !(p_out > 0);
		end
		inc_x = signed'(D_W'({x, 1'b0})) + signed'(D_W'(3));
		inc_y = signed'(D_W'(3)) - signed'(D_W'({y, 1'b0}));
		nxt.x = x + cpg_pkg::X_W'(dx);
		nxt.y = y - cpg_pkg::Y_W'(dy);
		nxt.d = d + (dx ? inc_x : '0) + (dy ? inc_y : '0);
	end

endmodule
`default_nettype wire

// ===== sv/cpg_replay.sv =====
`default_nettype none
module cpg_replay (
	input  wire logic [cpg_pkg::K_W-1:0]   k,
	input  wire logic [cpg_pkg::CNT_W-1:0] n,
	output cpg_pkg::replay_sel_t           sel
);

	localparam int K_W = cpg_pkg::K_W;

	logic [K_W-1:0] kk;
	logic [K_W-1:0] nn;
	logic [K_W-1:0] two_n;
	logic [K_W-1:0] four_n;
	logic [K_W-1:0] m;
	logic [K_W-1:0] idx;

	// fold the outline index onto the stored quadrant
	always_comb begin
		kk     = k;
		nn     = K_W'(n);
		two_n  = nn << 1;
		four_n = nn << 2;
		sel.neg_x = 1'b0;
		sel.neg_y = 1'b0;
		if (kk <= two_n) begin
			m = kk;
		end else begin
			m = four_n - kk;
			sel.neg_x = 1'b1;
		end
		if (m <= nn) begin
			idx = m;
		end else begin
			idx = two_n - m;
			sel.neg_y = 1'b1;
		end
		sel.idx  = cpg_pkg::CNT_W'(idx);
		sel.last = ((kk + K_W'(1)) >= four_n);
	end

endmodule
`default_nettype wire

// ===== tb/tb_circle_point_generator_unit.sv =====
`default_nettype none
module tb_circle_point_generator_unit;

	localparam int ITEMS = 2000;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [cpg_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int STALL_NONE = 0;
	localparam int STALL_LIGHT = 1;
	localparam int STALL_HEAVY = 2;
	localparam int STALL_ALTERNATE = 3;

	typedef struct packed {
		logic signed [cpg_pkg::PT_W-1:0] x;
		logic signed [cpg_pkg::PT_W-1:0] y;
		logic                            last;
	} outline_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [cpg_pkg::IDX_W-1:0] cfg_index = '0;
	logic [cpg_pkg::C_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [cpg_pkg::PT_W-1:0] point_x;
	logic signed [cpg_pkg::PT_W-1:0] point_y;
	logic last_point;

	circle_point_generator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [cpg_pkg::C_W-1:0] ctr_x = '0;
	logic [cpg_pkg::C_W-1:0] ctr_y = '0;
	logic [cpg_pkg::R_W-1:0] rad_reg = '0;
	int arc_x [0:511];
	int arc_y [0:511];
	int arc_n = 0;
	int walk_pos = 0;
	bit drawing = 0;
	outline_pt_t expected_pts[$];

	// stimulus and bookkeeping
	bit restart_q[$];
	int items_queued = 0;
	int items_taken = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	bit in_taken = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = STALL_NONE;
	int mode_left = 0;

	task automatic trace_quadrant(input int r);
		int x, y, d, p, cnt;
		bit mx, my;
		x = 0;
		y = r;
		cnt = 0;
		arc_x[0] = 0;
		arc_y[0] = r;
		while (y > 0) begin
			d = (x + 1) * (x + 1) + (y - 1) * (y - 1) - r * r;
			mx = 1;
			my = 1;
			if (d < 0) begin
				p = 4 * (x + 1) * (x + 1) + (2 * y - 1) * (2 * y - 1) - 4 * r * r;
				if (p <= 0) my = 0;
			end else if (d > 0) begin
				p = (2 * x + 1) * (2 * x + 1) + 4 * (y - 1) * (y - 1) - 4 * r * r;
				if (p > 0) mx = 0;
			end
			if (mx) x++;
			if (my) y--;
			cnt++;
			arc_x[cnt] = x;
			arc_y[cnt] = y;
		end
		arc_n = cnt;
	endtask

	function automatic void outline_offset(input int k, output int ox, output int oy);
		int m;
		bit flip_x;
		m = k;
		flip_x = 0;
		if (k > 2 * arc_n) begin
			m = 4 * arc_n - k;
			flip_x = 1;
		end
		if (m <= arc_n) begin
			ox = arc_x[m];
			oy = arc_y[m];
		end else begin
			ox = arc_x[2 * arc_n - m];
			oy = -arc_y[2 * arc_n - m];
		end
		if (flip_x) ox = -ox;
	endfunction

	task automatic predict_point(input logic rs);
		int ox, oy, px, py;
		outline_pt_t p;
		if (rs) begin
			walk_pos = 0;
			if (rad_reg == 0) begin
				drawing = 0;
				arc_n = 0;
			end else begin
				trace_quadrant(int'(rad_reg));
				drawing = 1;
			end
		end
		if (drawing) begin
			outline_offset(walk_pos, ox, oy);
			px = $signed(ctr_x) + ox;
			py = $signed(ctr_y) - oy;
			p.x = px[cpg_pkg::PT_W-1:0];
			p.y = py[cpg_pkg::PT_W-1:0];
			p.last = (walk_pos + 1 >= 4 * arc_n);
			expected_pts.push_back(p);
			if (p.last) begin
				drawing = 0;
				walk_pos = 0;
			end else begin
				walk_pos++;
			end
		end
	endtask

	always @(posedge clk) begin : observe
		outline_pt_t want;
		bit fired;
		fired = 0;
		if (cfg_valid && cfg_ready) begin
			fired = 1;
			case (cfg_index)
				cpg_pkg::REG_CENTER_X: ctr_x = cfg_data;
				cpg_pkg::REG_CENTER_Y: ctr_y = cfg_data;
				cpg_pkg::REG_RADIUS: rad_reg = cfg_data[cpg_pkg::R_W-1:0];
				default: ;
			endcase
		end
		in_taken = in_valid && !in_stall;
		if (in_taken) begin
			fired = 1;
			items_taken++;
			predict_point(restart);
		end
		if (out_valid && !out_stall) begin
			fired = 1;
			if (expected_pts.size() == 0) begin
				$error("unexpected point (%0d, %0d) last %0b", point_x, point_y, last_point);
				fail_count++;
			end else begin
				want = expected_pts.pop_front();
				if (point_x !== want.x) begin
					$error("point_x: expected %0d, got %0d", want.x, point_x);
					fail_count++;
				end
				if (point_y !== want.y) begin
					$error("point_y: expected %0d, got %0d", want.y, point_y);
					fail_count++;
				end
				if (last_point !== want.last) begin
					$error("last_point: expected %0b, got %0b", want.last, last_point);
					fail_count++;
				end
			end
		end
		if (fired) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin : drive
		logic nv, nr, ns;
		nv = in_valid;
		nr = restart;
		if (!in_valid || in_taken) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (restart_q.size() != 0) begin
				nr = restart_q.pop_front();
				nv = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end
		end
		in_valid <= nv;
		restart <= nr;

		if (mode_left == 0) begin
			stall_mode = $urandom_range(STALL_NONE, STALL_ALTERNATE);
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_LIGHT: ns = ($urandom_range(0, 99) < 30);
			STALL_HEAVY: ns = ($urandom_range(0, 99) < 80);
			STALL_ALTERNATE: ns = !out_stall;
			default: ns = 1'b0;
		endcase
		out_stall <= ns;
	end

	task automatic push_item(input bit rs);
		restart_q.push_back(rs);
		items_queued++;
	endtask

	task automatic settle();
		while (items_taken != items_queued || expected_pts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// call at a falling edge; returns at a falling edge with valid low
	task automatic write_reg(input logic [cpg_pkg::IDX_W-1:0] idx,
		input logic [cpg_pkg::C_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [cpg_pkg::C_W-1:0] pick_center();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) return 12'h800;
		if (sel == 1) return 12'h7FF;
		if (sel == 2) return 12'h000;
		return cpg_pkg::C_W'($urandom_range(0, 4095));
	endfunction

	function automatic int pick_radius();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) return 0;
		if (sel < 78) return $urandom_range(1, 10);
		if (sel < 97) return $urandom_range(11, 40);
		return $urandom_range(41, 255);
	endfunction

	initial begin : stimulus
		int r, cur_radius, nseq, len;
		bit wrote;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle advances, spare register, zero-radius restart
		write_reg(REG_SPARE, cpg_pkg::C_W'($urandom_range(0, 4095)));
		push_item(0);
		push_item(0);
		push_item(1);
		settle();

		// radius 1 at extreme centres; advance past the end; restart mid-circle
		write_reg(cpg_pkg::REG_CENTER_X, 12'h7FF);
		write_reg(cpg_pkg::REG_CENTER_Y, 12'h800);
		write_reg(cpg_pkg::REG_RADIUS, 12'hF01);
		push_item(1);
		repeat (4) push_item(0);
		push_item(1);
		push_item(0);
		push_item(1);
		push_item(0);
		settle();

		// largest radius at the opposite extremes; run the whole outline and past it
		write_reg(cpg_pkg::REG_CENTER_X, 12'h800);
		write_reg(cpg_pkg::REG_CENTER_Y, 12'h7FF);
		write_reg(cpg_pkg::REG_RADIUS, 12'h0FF);
		push_item(1);
		repeat (1500) push_item(0);
		settle();

		// move the centre in mid-circle, then restart with zero radius
		write_reg(cpg_pkg::REG_CENTER_X, 12'h000);
		write_reg(cpg_pkg::REG_CENTER_Y, 12'h000);
		write_reg(cpg_pkg::REG_RADIUS, 12'h002);
		push_item(1);
		repeat (2) push_item(0);
		settle();
		write_reg(cpg_pkg::REG_CENTER_X, 12'd100);
		repeat (2) push_item(0);
		settle();
		write_reg(cpg_pkg::REG_RADIUS, 12'h000);
		push_item(1);
		push_item(0);
		settle();

		cur_radius = 0;
		while (items_queued < ITEMS) begin
			wrote = 0;
			while (!wrote) begin
				if ($urandom_range(0, 1)) begin
					write_reg(cpg_pkg::REG_CENTER_X, pick_center());
					wrote = 1;
				end
				if ($urandom_range(0, 1)) begin
					write_reg(cpg_pkg::REG_CENTER_Y, pick_center());
					wrote = 1;
				end
				if ($urandom_range(0, 1)) begin
					cur_radius = pick_radius();
					write_reg(cpg_pkg::REG_RADIUS,
						{4'($urandom_range(0, 15)), 8'(cur_radius)});
					wrote = 1;
				end
			end
			nseq = $urandom_range(1, 4);
			repeat (nseq) begin
				if ($urandom_range(0, 9) < 8) begin
					r = cur_radius;
					if (r == 0) len = $urandom_range(0, 3);
					else if (r > 40) len = $urandom_range(1, 20);
					else len = $urandom_range(4 * r, 8 * r + 2);
					push_item(1);
					repeat (len) push_item(0);
				end else begin
					len = $urandom_range(1, 12);
					repeat (len) push_item($urandom_range(0, 9) < 3);
				end
			end
			settle();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_pts.size() != 0) begin
			$error("%0d expected points never arrived", expected_pts.size());
			fail_count++;
		end
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/cpg_pkg.sv
sv/cpg_walker.sv
sv/cpg_replay.sv
sv/circle_point_generator_unit.sv
tb/tb_circle_point_generator_unit.sv
